// File: rtl/lfc_pkg.sv
package lfc_pkg;

  localparam int XW    = 16;
  localparam int FITW  = 32;
  localparam int CHIW  = 40;
  localparam int STW   = 2;
  localparam int PTW   = 4 * XW;
  localparam int ALUW  = 128;

  localparam logic [STW-1:0] ST_OK         = 2'd0;
  localparam logic [STW-1:0] ST_DEGEN      = 2'd1;
  localparam logic [STW-1:0] ST_ZERO_SIGMA = 2'd2;
  localparam logic [STW-1:0] ST_SAT        = 2'd3;

  localparam logic [CHIW-1:0] CHI_MAX = {CHIW{1'b1}};
  localparam logic [FITW-1:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [FITW-1:0] S32_MIN = 32'h8000_0000;
  localparam int              MIN_FIT_POINTS = 3;

  // datapath operations, one per controller step
  typedef enum logic [4:0] {
    OP_NONE,
    OP_M_NSXX,
    OP_M_SXSX,
    OP_DENOM,
    OP_M_NSXY,
    OP_M_SXSY,
    OP_D_SLOPE,
    OP_SLOPE,
    OP_D_ICPT,
    OP_ICPT,
    OP_RD,
    OP_PX,
    OP_M_RES,
    OP_M_SIG,
    OP_D_CHI,
    OP_ACC,
    OP_D_DOF,
    OP_FIN,
    OP_FDEG
  } lfc_op_t;

  typedef struct packed {
    logic    accept;
    lfc_op_t op;
  } lfc_cmd_t;

  typedef struct packed {
    logic alu_done;
    logic degen;
    logic last_pt;
    logic out_free;
  } lfc_stat_t;

endpackage

// File: rtl/lfc_ram.sv
module lfc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: rtl/lfc_alu.sv
module lfc_alu (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic                    is_div,
  input  logic [lfc_pkg::ALUW-1:0] opa,
  input  logic [lfc_pkg::ALUW-1:0] opb,
  output logic [lfc_pkg::ALUW-1:0] result,
  output logic                    done
);
  import lfc_pkg::*;

  localparam int MUL_STEPS = ALUW / 2;
  localparam int CNTW      = $clog2(ALUW);

  logic [ALUW-1:0] acc_r;
  logic [ALUW-1:0] w_r;
  logic [ALUW-1:0] v_r;
  logic [CNTW-1:0] cnt_r;
  logic            div_r;
  logic            busy_r;
  logic            done_r;

  logic [ALUW:0]   rem_shift;
  logic [ALUW:0]   rem_diff;
  logic            rem_ge;

  // divide: shift one numerator bit into the remainder, subtract when it fits
  assign rem_shift = {acc_r, w_r[ALUW-1]};
  assign rem_diff  = rem_shift - {1'b0, v_r};
  assign rem_ge    = (rem_shift >= {1'b0, v_r});

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      w_r   <= opa;
      v_r   <= opb;
      div_r <= is_div;
      cnt_r <= is_div ? CNTW'(ALUW - 1) : CNTW'(MUL_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CNTW'(1);
      if (div_r) begin
        acc_r <= rem_ge ? rem_diff[ALUW-1:0] : rem_shift[ALUW-1:0];
        w_r   <= {w_r[ALUW-2:0], rem_ge};
      end else begin
        if (v_r[0]) begin
          acc_r <= acc_r + w_r;
        end
        w_r <= {w_r[ALUW-2:0], 1'b0};
        v_r <= {1'b0, v_r[ALUW-1:1]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
      done_r <= 1'b1;
    end else begin
      done_r <= 1'b0;
    end
  end

  assign result = div_r ? w_r : acc_r;
  assign done   = done_r;

endmodule

// File: rtl/lfc_dp.sv
module lfc_dp #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lfc_pkg::lfc_cmd_t              cmd,
  output lfc_pkg::lfc_stat_t             stat,
  input  logic signed [lfc_pkg::XW-1:0]  x_value,
  input  logic signed [lfc_pkg::XW-1:0]  y_value,
  input  logic [lfc_pkg::XW-1:0]         x_error,
  input  logic [lfc_pkg::XW-1:0]         y_error,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic signed [lfc_pkg::FITW-1:0] slope,
  output logic signed [lfc_pkg::FITW-1:0] intercept,
  output logic [lfc_pkg::CHIW-1:0]       chi_square,
  output logic [lfc_pkg::CHIW-1:0]       chi_square_per_dof,
  output logic [lfc_pkg::STW-1:0]        status
);
  import lfc_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  function automatic logic [63:0] abs64(input logic [63:0] v);
    return v[63] ? (~v + 64'd1) : v;
  endfunction

  // saturate a signed quotient given as magnitude and sign, bit 32 flags saturation
  function automatic logic [FITW:0] sat_q(input logic [ALUW-1:0] q, input logic neg);
    logic [FITW:0] r;
    if (|q[ALUW-1:FITW]) begin
      r = {1'b1, neg ? S32_MIN : S32_MAX};
    end else if (neg) begin
      if (q[FITW-1:0] > S32_MIN) r = {1'b1, S32_MIN};
      else                       r = {1'b0, ~q[FITW-1:0] + 32'd1};
    end else begin
      if (q[FITW-1]) r = {1'b1, S32_MAX};
      else           r = {1'b0, q[FITW-1:0]};
    end
    return r;
  endfunction

  // accumulation state
  logic [CW-1:0]        cnt_r;
  logic signed [47:0]   sx_r;
  logic signed [47:0]   sy_r;
  logic signed [63:0]   sxx_r;
  logic signed [63:0]   sxy_r;
  logic                 drop_r;

  // fit state
  logic [63:0]          t1_r;
  logic [63:0]          denom_r;
  logic                 sign_r;
  logic                 numneg_r;
  logic                 tneg_r;
  logic signed [FITW-1:0] a_r;
  logic signed [FITW-1:0] b_r;
  logic [63:0]          am2_r;
  logic [CHIW-1:0]      chi_r;
  logic                 sat_r;
  logic                 zs_r;
  logic                 szero_r;
  logic [AW-1:0]        idx_r;
  logic signed [47:0]   prod_r;
  logic signed [XW-1:0] py_r;
  logic [XW-1:0]        psx_r;
  logic [XW-1:0]        psy_r;
  logic [31:0]          psx2_r;
  logic [ALUW-1:0]      rm2_r;

  // result register
  logic                 out_valid_r;
  logic [FITW-1:0]      slope_r;
  logic [FITW-1:0]      icpt_r;
  logic [CHIW-1:0]      chi_out_r;
  logic [CHIW-1:0]      dof_out_r;
  logic [STW-1:0]       status_r;

  logic                 alu_start;
  logic                 alu_div;
  logic [ALUW-1:0]      alu_a;
  logic [ALUW-1:0]      alu_b;
  logic [ALUW-1:0]      alu_res;
  logic                 alu_done;

  logic                 full;
  logic                 ram_we;
  logic                 ram_re;
  logic [PTW-1:0]       ram_rdata;

  logic [63:0]          n64;
  logic [63:0]          sx64;
  logic [63:0]          sy64;
  logic [63:0]          pl;
  logic [63:0]          pl_s;
  logic [63:0]          num_c;
  logic [63:0]          t_c;
  logic [FITW:0]        a_sq;
  logic [FITW:0]        b_sq;
  logic [FITW-1:0]      am_nxt;
  logic [FITW-1:0]      am_cur;
  logic [63:0]          res_c;
  logic [63:0]          rm_c;
  logic [31:0]          psy2_c;
  logic [ALUW-1:0]      s_c;
  logic [CHIW-1:0]      lim_c;
  logic                 term_big;
  logic                 fin;

  assign full   = (cnt_r == CW'(MAX_POINTS));
  assign ram_we = cmd.accept && !full;
  assign ram_re = (cmd.op == OP_RD);

  assign n64  = 64'(cnt_r);
  assign sx64 = 64'(sx_r);
  assign sy64 = 64'(sy_r);
  assign pl   = alu_res[63:0];
  assign pl_s = sign_r ? (~pl + 64'd1) : pl;
  assign num_c = t1_r - pl_s;
  assign t_c   = {sy64[47:0], 16'b0} - pl_s;

  assign a_sq   = sat_q(alu_res, numneg_r);
  assign b_sq   = sat_q(alu_res, tneg_r);
  assign am_nxt = a_sq[FITW-1] ? (~a_sq[FITW-1:0] + 32'd1) : a_sq[FITW-1:0];
  assign am_cur = a_r[FITW-1] ? (~a_r + 32'd1) : a_r;

  // residual in Q.16: y - a*x - b
  assign res_c  = {{32{py_r[XW-1]}}, py_r, 16'b0} - 64'(prod_r) -
                  {{24{b_r[FITW-1]}}, b_r, 8'b0};
  assign rm_c   = abs64(res_c);
  assign psy2_c = 32'(psy_r) * 32'(psy_r);
  assign s_c    = {64'b0, psy2_c, 32'b0} + alu_res;
  assign lim_c  = CHI_MAX - chi_r;
  assign term_big = (|alu_res[ALUW-1:CHIW]) || (alu_res[CHIW-1:0] > lim_c);

  assign fin = (cmd.op == OP_FIN) || (cmd.op == OP_FDEG);

  always_comb begin
    alu_start = 1'b0;
    alu_div   = 1'b0;
    alu_a     = '0;
    alu_b     = '0;
    unique case (cmd.op)
      OP_M_NSXX: begin
        alu_start = 1'b1;
        alu_a     = {64'b0, n64};
        alu_b     = {64'b0, sxx_r};
      end
      OP_M_SXSX: begin
        alu_start = 1'b1;
        alu_a     = {64'b0, abs64(sx64)};
        alu_b     = {64'b0, abs64(sx64)};
      end
      OP_M_NSXY: begin
        alu_start = 1'b1;
        alu_a     = {64'b0, n64};
        alu_b     = {64'b0, abs64(sxy_r)};
      end
      OP_M_SXSY: begin
        alu_start = 1'b1;
        alu_a     = {64'b0, abs64(sx64)};
        alu_b     = {64'b0, abs64(sy64)};
      end
      OP_D_SLOPE: begin
        alu_start = 1'b1;
        alu_div   = 1'b1;
        alu_a     = {48'b0, abs64(num_c), 16'b0};
        alu_b     = {64'b0, denom_r};
      end
      OP_SLOPE: begin
        alu_start = 1'b1;
        alu_a     = {96'b0, am_nxt};
        alu_b     = {64'b0, abs64(sx64)};
      end
      OP_D_ICPT: begin
        alu_start = 1'b1;
        alu_div   = 1'b1;
        alu_a     = {64'b0, abs64(t_c)};
        alu_b     = {64'b0, n64[55:0], 8'b0};
      end
      OP_M_RES: begin
        alu_start = 1'b1;
        alu_a     = {64'b0, rm_c};
        alu_b     = {64'b0, rm_c};
      end
      OP_M_SIG: begin
        alu_start = 1'b1;
        alu_a     = {64'b0, am2_r};
        alu_b     = {96'b0, psx2_r};
      end
      OP_D_CHI: begin
        alu_start = 1'b1;
        alu_div   = 1'b1;
        alu_a     = {rm2_r[ALUW-17:0], 16'b0};
        alu_b     = s_c;
      end
      OP_D_DOF: begin
        alu_start = 1'b1;
        alu_div   = 1'b1;
        alu_a     = {88'b0, chi_r};
        alu_b     = {64'b0, n64 - 64'd2};
      end
      default: begin
        alu_start = 1'b0;
      end
    endcase
  end

  lfc_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (alu_start),
    .is_div (alu_div),
    .opa    (alu_a),
    .opb    (alu_b),
    .result (alu_res),
    .done   (alu_done)
  );

  lfc_ram #(
    .WIDTH (PTW),
    .DEPTH (MAX_POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cnt_r[AW-1:0]),
    .wr_data ({y_error, x_error, y_value, x_value}),
    .rd_en   (ram_re),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  // point sums and count
  always_ff @(posedge clk) begin
    if (!rst_n || fin) begin
      cnt_r  <= '0;
      sx_r   <= '0;
      sy_r   <= '0;
      sxx_r  <= '0;
      sxy_r  <= '0;
      drop_r <= 1'b0;
    end else if (cmd.accept) begin
      if (full) begin
        drop_r <= 1'b1;
      end else begin
        cnt_r <= cnt_r + CW'(1);
        sx_r  <= sx_r + 48'(x_value);
        sy_r  <= sy_r + 48'(y_value);
        sxx_r <= sxx_r + 64'(32'(x_value) * 32'(x_value));
        sxy_r <= sxy_r + 64'(32'(x_value) * 32'(y_value));
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_M_SXSX: t1_r <= pl;
      OP_DENOM: begin
        denom_r <= t1_r - pl;
        sat_r   <= drop_r;
      end
      OP_M_NSXY: sign_r <= sxy_r[63];
      OP_M_SXSY: begin
        t1_r   <= pl_s;
        sign_r <= sx_r[47] ^ sy_r[47];
      end
      OP_D_SLOPE: numneg_r <= num_c[63];
      OP_SLOPE: begin
        a_r    <= a_sq[FITW-1:0];
        sat_r  <= sat_r | a_sq[FITW];
        sign_r <= a_sq[FITW-1] ^ sx_r[47];
      end
      OP_D_ICPT: begin
        tneg_r <= t_c[63];
        am2_r  <= 64'(am_cur) * 64'(am_cur);
      end
      OP_ICPT: begin
        b_r   <= b_sq[FITW-1:0];
        sat_r <= sat_r | b_sq[FITW];
        chi_r <= '0;
        zs_r  <= 1'b0;
        idx_r <= '0;
      end
      OP_PX: begin
        prod_r <= 48'(a_r) * 48'(signed'(ram_rdata[XW-1:0]));
        py_r   <= ram_rdata[2*XW-1:XW];
        psx_r  <= ram_rdata[3*XW-1:2*XW];
        psy_r  <= ram_rdata[4*XW-1:3*XW];
      end
      OP_M_RES: psx2_r <= 32'(psx_r) * 32'(psx_r);
      OP_M_SIG: rm2_r <= alu_res;
      OP_D_CHI: szero_r <= (s_c == '0);
      OP_ACC: begin
        idx_r <= idx_r + AW'(1);
        if (szero_r) begin
          zs_r <= 1'b1;
        end else if (term_big) begin
          chi_r <= CHI_MAX;
          sat_r <= 1'b1;
        end else begin
          chi_r <= chi_r + alu_res[CHIW-1:0];
        end
      end
      OP_FIN: begin
        slope_r <= a_r;
        icpt_r  <= b_r;
        if (zs_r) begin
          chi_out_r <= '0;
          dof_out_r <= '0;
          status_r  <= ST_ZERO_SIGMA;
        end else begin
          chi_out_r <= chi_r;
          dof_out_r <= alu_res[CHIW-1:0];
          status_r  <= sat_r ? ST_SAT : ST_OK;
        end
      end
      OP_FDEG: begin
        slope_r   <= '0;
        icpt_r    <= '0;
        chi_out_r <= '0;
        dof_out_r <= '0;
        status_r  <= ST_DEGEN;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign stat.alu_done = alu_done;
  assign stat.degen    = (cnt_r < CW'(MIN_FIT_POINTS)) || denom_r[63] || (denom_r == '0);
  assign stat.last_pt  = (CW'(idx_r) == cnt_r - CW'(1));
  assign stat.out_free = !out_valid_r || !out_stall;

  assign out_valid          = out_valid_r;
  assign slope              = slope_r;
  assign intercept          = icpt_r;
  assign chi_square         = chi_out_r;
  assign chi_square_per_dof = dof_out_r;
  assign status             = status_r;

endmodule

// File: rtl/lfc_ctrl.sv
module lfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_last_point,
  input  lfc_pkg::lfc_stat_t stat,
  output logic               in_stall,
  output lfc_pkg::lfc_cmd_t  cmd
);
  import lfc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_WAIT,
    S_MNSXX,
    S_MSXSX,
    S_DENOM,
    S_CHK,
    S_MNSXY,
    S_MSXSY,
    S_DSLOPE,
    S_SLOPE,
    S_DICPT,
    S_ICPT,
    S_RD,
    S_PX,
    S_MRES,
    S_MSIG,
    S_DCHI,
    S_ACC,
    S_DDOF,
    S_FIN,
    S_FDEG
  } state_t;

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt;

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd.accept = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        cmd.accept = in_valid;
        if (in_valid && in_last_point) state_nxt = S_MNSXX;
      end
      S_WAIT: begin
        if (stat.alu_done) state_nxt = ret_r;
      end
      S_MNSXX: begin
        cmd.op = OP_M_NSXX; state_nxt = S_WAIT; ret_nxt = S_MSXSX;
      end
      S_MSXSX: begin
        cmd.op = OP_M_SXSX; state_nxt = S_WAIT; ret_nxt = S_DENOM;
      end
      S_DENOM: begin
        cmd.op = OP_DENOM; state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = stat.degen ? S_FDEG : S_MNSXY;
      end
      S_MNSXY: begin
        cmd.op = OP_M_NSXY; state_nxt = S_WAIT; ret_nxt = S_MSXSY;
      end
      S_MSXSY: begin
        cmd.op = OP_M_SXSY; state_nxt = S_WAIT; ret_nxt = S_DSLOPE;
      end
      S_DSLOPE: begin
        cmd.op = OP_D_SLOPE; state_nxt = S_WAIT; ret_nxt = S_SLOPE;
      end
      S_SLOPE: begin
        cmd.op = OP_SLOPE; state_nxt = S_WAIT; ret_nxt = S_DICPT;
      end
      S_DICPT: begin
        cmd.op = OP_D_ICPT; state_nxt = S_WAIT; ret_nxt = S_ICPT;
      end
      S_ICPT: begin
        cmd.op = OP_ICPT; state_nxt = S_RD;
      end
      S_RD: begin
        cmd.op = OP_RD; state_nxt = S_PX;
      end
      S_PX: begin
        cmd.op = OP_PX; state_nxt = S_MRES;
      end
      S_MRES: begin
        cmd.op = OP_M_RES; state_nxt = S_WAIT; ret_nxt = S_MSIG;
      end
      S_MSIG: begin
        cmd.op = OP_M_SIG; state_nxt = S_WAIT; ret_nxt = S_DCHI;
      end
      S_DCHI: begin
        cmd.op = OP_D_CHI; state_nxt = S_WAIT; ret_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.op    = OP_ACC;
        state_nxt = stat.last_pt ? S_DDOF : S_RD;
      end
      S_DDOF: begin
        cmd.op = OP_D_DOF; state_nxt = S_WAIT; ret_nxt = S_FIN;
      end
      S_FIN: begin
        // hold until the result register can take the new beat
        if (stat.out_free) begin
          cmd.op = OP_FIN; state_nxt = S_IDLE;
        end
      end
      S_FDEG: begin
        if (stat.out_free) begin
          cmd.op = OP_FDEG; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r   <= S_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

// File: rtl/line_fit_with_chi_square_core.sv
// channel | ports                                         | beat taken when
// in      | in_valid in_stall in_x/y_value in_x/y_error   | in_valid & !in_stall
//         | in_last_point                                 |
// out     | out_valid out_stall out_slope out_intercept   | out_valid & !out_stall
//         | out_chi_square out_chi_square_per_dof out_status |
// points are taken one per cycle while no fit runs; a point with last_point starts the fit
// the fit runs on the shared shift-add / shift-subtract unit, which forms each product and
// quotient; each point read back takes 2 products and 1 quotient, and a degenerate set ends
// after the denominator check with no slope or point pass
// rst_n is synchronous; it clears count, sums and valid flags, the point memory is not cleared
// new points are taken while a result waits on out_stall; a fit waits at its end for the slot
module line_fit_with_chi_square_core #(
  parameter int MAX_POINTS = 1024
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [lfc_pkg::XW-1:0]    in_x_value,
  input  logic signed [lfc_pkg::XW-1:0]    in_y_value,
  input  logic [lfc_pkg::XW-1:0]           in_x_error,
  input  logic [lfc_pkg::XW-1:0]           in_y_error,
  input  logic                             in_last_point,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [lfc_pkg::FITW-1:0]  out_slope,
  output logic signed [lfc_pkg::FITW-1:0]  out_intercept,
  output logic [lfc_pkg::CHIW-1:0]         out_chi_square,
  output logic [lfc_pkg::CHIW-1:0]         out_chi_square_per_dof,
  output logic [lfc_pkg::STW-1:0]          out_status
);
  import lfc_pkg::*;

  lfc_cmd_t  cmd;
  lfc_stat_t stat;

  lfc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .stat          (stat),
    .in_stall      (in_stall),
    .cmd           (cmd)
  );

  lfc_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .x_value            (in_x_value),
    .y_value            (in_y_value),
    .x_error            (in_x_error),
    .y_error            (in_y_error),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .slope              (out_slope),
    .intercept          (out_intercept),
    .chi_square         (out_chi_square),
    .chi_square_per_dof (out_chi_square_per_dof),
    .status             (out_status)
  );

endmodule

// File: rtl/lfc_checker.sv
module lfc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic signed [lfc_pkg::XW-1:0]    in_x_value,
  input logic signed [lfc_pkg::XW-1:0]    in_y_value,
  input logic [lfc_pkg::XW-1:0]           in_x_error,
  input logic [lfc_pkg::XW-1:0]           in_y_error,
  input logic                             in_last_point,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [lfc_pkg::FITW-1:0]  out_slope,
  input logic signed [lfc_pkg::FITW-1:0]  out_intercept,
  input logic [lfc_pkg::CHIW-1:0]         out_chi_square,
  input logic [lfc_pkg::CHIW-1:0]         out_chi_square_per_dof,
  input logic [lfc_pkg::STW-1:0]          out_status
);
  import lfc_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slope) &&
      $stable(out_chi_square) && $stable(out_status))
    else $error("result changed under stall");

  // the last point of a set starts the fit, which blocks further points
  a_fit_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_point |=> in_stall)
    else $error("input open right after last point");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DEGEN |-> out_slope == '0 && out_intercept == '0 &&
      out_chi_square == '0 && out_chi_square_per_dof == '0)
    else $error("degenerate result not cleared");

  a_zs_chi: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ZERO_SIGMA |->
      out_chi_square == '0 && out_chi_square_per_dof == '0)
    else $error("zero sigma result carries chi square");

  // at least three points, so the per-dof value never exceeds the sum
  a_dof_le: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_SAT) |->
      out_chi_square_per_dof <= out_chi_square)
    else $error("chi square per dof above chi square");

endmodule

bind line_fit_with_chi_square_core lfc_checker u_lfc_checker (.*);

// File: test/line_fit_with_chi_square_core_test.sv
`timescale 1ns / 1ps

module line_fit_with_chi_square_core_test;
  import lfc_pkg::*;

  localparam int MAX_PTS = 1024;

  typedef struct {
    logic signed [FITW-1:0] slope;
    logic signed [FITW-1:0] intercept;
    logic [CHIW-1:0]        chi;
    logic [CHIW-1:0]        chi_dof;
    logic [STW-1:0]         status;
  } fit_result_t;

  class fit_board;
    fit_result_t pending[$];
    logic [63:0] pts [MAX_PTS];
    int unsigned count;
    longint      sx, sy, sxx, sxy;
    bit          dropped;
    int          fails;

    function void clear_set();
      count = 0; sx = 0; sy = 0; sxx = 0; sxy = 0; dropped = 0;
    endfunction

    // adds one point to the running set (or marks it dropped when full); on the closing point the fit result is queued
    function void note_point(logic signed [15:0] x, logic signed [15:0] y,
                             logic [15:0] ex, logic [15:0] ey, logic last);
      fit_result_t r;
      longint n, denom, num, a, b, t, px, py, res;
      logic [127:0] mag, quot, rm, am, s, term, chi, psx, psy;
      bit sat, zsig;
      if (count < MAX_PTS) begin
        pts[count] = {ey, ex, y, x};
        count++;
        sx += x; sy += y; sxx += longint'(x) * x; sxy += longint'(x) * y;
      end else dropped = 1;
      if (!last) return;
      r = '{0, 0, 0, 0, ST_DEGEN};
      n = count;
      denom = n * sxx - sx * sx;
      if (n < MIN_FIT_POINTS || denom <= 0) begin
        pending = {pending, r};
        clear_set();
        return;
      end
      sat = dropped; zsig = 0; chi = 0;
      num = n * sxy - sx * sy;
      mag = (num < 0) ? -num : num;
      if (mag / denom >= 65536) begin
        sat = 1;
        a = (num < 0) ? -64'sd2147483648 : 64'sd2147483647;
      end else begin
        quot = (mag << 16) / denom;
        a = (num < 0) ? -longint'(quot) : longint'(quot);
        if (a > 64'sd2147483647) begin a = 64'sd2147483647; sat = 1; end
        if (a < -64'sd2147483648) begin a = -64'sd2147483648; sat = 1; end
      end
      t = sy * 65536 - a * sx;
      b = t / (n * 256);
      if (b > 64'sd2147483647) begin b = 64'sd2147483647; sat = 1; end
      if (b < -64'sd2147483648) begin b = -64'sd2147483648; sat = 1; end
      am = (a < 0) ? -a : a;
      for (int i = 0; i < count; i++) begin
        px = longint'($signed(pts[i][15:0]));
        py = longint'($signed(pts[i][31:16]));
        psx = pts[i][47:32];
        psy = pts[i][63:48];
        res = py * 65536 - a * px - b * 256;
        rm = (res < 0) ? -res : res;
        s = ((psy * psy) << 32) + am * am * psx * psx;
        if (s == 0) begin
          zsig = 1;
          continue;
        end
        term = ((rm * rm) << 16) / s;
        if (term > {88'b0, CHI_MAX} - chi) begin
          chi = {88'b0, CHI_MAX};
          sat = 1;
        end else chi += term;
      end
      r.slope = a[31:0];
      r.intercept = b[31:0];
      if (zsig) r.status = ST_ZERO_SIGMA;
      else begin
        r.chi = chi[CHIW-1:0];
        r.chi_dof = CHIW'(chi / (n - 2));
        r.status = sat ? ST_SAT : ST_OK;
      end
      pending = {pending, r};
      clear_set();
    endfunction

    function void check_result(fit_result_t got);
      fit_result_t e;
      if (pending.size() == 0) begin
        fails++;
        if (fails <= 10) $display("unexpected result beat: status %0d", got.status);
        return;
      end
      e = pending.pop_front();
      if (got.slope !== e.slope || got.intercept !== e.intercept || got.chi !== e.chi ||
          got.chi_dof !== e.chi_dof || got.status !== e.status) begin
        fails++;
        if (fails <= 10)
          $display("mismatch: exp a=%h b=%h chi=%h dof=%h st=%0d got a=%h b=%h chi=%h dof=%h st=%0d",
                   e.slope, e.intercept, e.chi, e.chi_dof, e.status,
                   got.slope, got.intercept, got.chi, got.chi_dof, got.status);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  logic signed [XW-1:0] in_x_value = 0, in_y_value = 0;
  logic [XW-1:0] in_x_error = 0, in_y_error = 0;
  logic in_last_point = 0;
  logic out_valid, out_stall = 0;
  logic signed [FITW-1:0] out_slope, out_intercept;
  logic [CHIW-1:0] out_chi_square, out_chi_square_per_dof;
  logic [STW-1:0] out_status;

  fit_board board = new();
  bit calm = 0;
  bit hold_req = 0;
  int sent = 0;

  line_fit_with_chi_square_core #(.MAX_POINTS(MAX_PTS)) uut (.*);

  always #5 clk = ~clk;

  initial begin
    #30ms;
    $display("Test completed with failures");
    $finish;
  end

  // result side: random stall, plus one long hold-off on request
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1;
        hold--;
      end else if (hold_req) begin
        hold_req = 0;
        hold = 5000;
        out_stall <= 1;
      end else out_stall <= !calm && ($urandom_range(99) < 7);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result('{out_slope, out_intercept, out_chi_square,
                           out_chi_square_per_dof, out_status});
  end

  // drives one point beat and waits for it to be taken; valid stays up for the next beat
  task automatic send_point(logic signed [15:0] x, logic signed [15:0] y,
                            logic [15:0] ex, logic [15:0] ey, logic last);
    while (!calm && $urandom_range(99) < 7) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_x_value <= x; in_y_value <= y;
    in_x_error <= ex; in_y_error <= ey; in_last_point <= last;
    do @(posedge clk); while (in_stall);
    board.note_point(x, y, ex, ey, last);
    sent++;
    @(negedge clk);
  endtask

  task automatic send_set(int npts, bit linear);
    int slope, icpt;
    logic signed [15:0] x, y;
    slope = $urandom_range(1024) - 512;
    icpt = $urandom_range(8192) - 4096;
    for (int i = 0; i < npts; i++) begin
      if (linear) begin
        x = 16'($urandom_range(8191) - 4096);
        y = 16'((longint'(x) * slope) / 256 + icpt + $urandom_range(64) - 32);
      end else begin
        x = 16'($urandom); y = 16'($urandom);
      end
      send_point(x, y, ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(255)),
                 ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(512, 1)),
                 i == npts - 1);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // degenerate sets: one point, two points, all x equal
    send_point(16'sd100, 16'sd50, 16'd10, 16'd10, 1'b1);
    send_point(16'sd100, 16'sd50, 16'd10, 16'd10, 1'b0);
    send_point(16'sd300, 16'sd90, 16'd10, 16'd10, 1'b1);
    send_point(16'sd5, 16'sd1, 16'd1, 16'd1, 1'b0);
    send_point(16'sd5, 16'sd2, 16'd1, 16'd1, 1'b0);
    send_point(16'sd5, 16'sd3, 16'd1, 16'd1, 1'b1);
    // zero sigma
    send_point(16'sd0, 16'sd10, 16'd0, 16'd0, 1'b0);
    send_point(16'sd256, 16'sd300, 16'd0, 16'd0, 1'b0);
    send_point(16'sd512, 16'sd500, 16'd0, 16'd0, 1'b1);
    // slope out of range
    send_point(16'sd0, -16'sd32768, 16'd1, 16'd1, 1'b0);
    send_point(16'sd0, -16'sd32768, 16'd1, 16'd1, 1'b0);
    send_point(16'sd1, 16'sd32767, 16'd1, 16'd1, 1'b1);
    // chi2 overflow from tiny sigma
    send_point(16'sd0, 16'sd0, 16'd0, 16'd1, 1'b0);
    send_point(16'sd256, 16'sd32767, 16'd0, 16'd1, 1'b0);
    send_point(16'sd512, -16'sd32768, 16'd0, 16'd1, 1'b0);
    send_point(16'sd768, 16'sd32767, 16'd0, 16'd1, 1'b1);
    // field extremes
    send_point(-16'sd32768, 16'sd32767, 16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'sd32767, -16'sd32768, 16'hFFFF, 16'hFFFF, 1'b0);
    send_point(16'sd0, 16'sd0, 16'h0000, 16'hFFFF, 1'b0);
    send_point(16'sd1, -16'sd1, 16'h8000, 16'h0001, 1'b1);
    drain();
    // overfilled store: points past the limit are dropped
    for (int i = 0; i < MAX_PTS + 6; i++)
      send_point(16'((i % 200) * 37 - 3700), 16'($urandom_range(4000)), 16'($urandom_range(64)),
                 16'($urandom_range(300, 1)), i == MAX_PTS + 5);
    drain();
    while (sent < 1400) begin
      calm = (sent > 1150 && sent < 1230);
      if (sent > 1240 && sent < 1250) hold_req = 1;
      n = ($urandom_range(19) == 0) ? $urandom_range(2, 1) : $urandom_range(12, 3);
      send_set(n, $urandom_range(9) < 8);
      if ($urandom_range(29) == 0) drain();
    end
    calm = 0;
    drain();
    repeat (50) @(posedge clk);
    if (board.fails == 0 && board.pending.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// File: sim.f
rtl/lfc_pkg.sv
rtl/lfc_ram.sv
rtl/lfc_alu.sv
rtl/lfc_dp.sv
rtl/lfc_ctrl.sv
rtl/line_fit_with_chi_square_core.sv
rtl/lfc_checker.sv
test/line_fit_with_chi_square_core_test.sv
